/* src/sct_pkg.sv */
package sct_pkg;

  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_SRAM_SIZE   = 2560;
  localparam int DEF_SRAM_BASE   = 256;

  localparam int OP_W    = 2;
  localparam int PC_W    = 14;
  localparam int ADDR_W  = 12;
  localparam int DEPTH_W = 7;
  localparam int FAULT_W = 2;
  localparam int MARK_W  = 2;

  localparam int IN_DATA_W  = ((2 * PC_W + ADDR_W + 7) / 8) * 8;
  localparam int OUT_BITS   = DEPTH_W + 2 * PC_W + FAULT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // power of two so the queue pointers wrap by themselves
  localparam int QUEUE_DEPTH = 2;

  localparam logic [OP_W-1:0] OP_CALL     = 2'd0;
  localparam logic [OP_W-1:0] OP_RET_ADDR = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE  = 2'd2;

  localparam logic [FAULT_W-1:0] FAULT_NONE      = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_OVERFLOW  = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_UNDERFLOW = 2'd2;

  localparam logic [MARK_W-1:0] MARK_NONE = 2'd0;
  localparam logic [MARK_W-1:0] MARK_HIGH = 2'd1;
  localparam logic [MARK_W-1:0] MARK_LOW  = 2'd2;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_MARK,
    CMD_RELEASE,
    CMD_REPORT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [PC_W-1:0]   target;
    logic [PC_W-1:0]   source;
    logic [ADDR_W-1:0] addr;
    logic              mark_below;
  } cmd_t;

endpackage

/* src/shadow_call_stack_tracker.sv */
// each event goes from ST_IDLE to ST_TOP and ST_RESULT, by way of ST_MARK_LOW
// for return-address events above the window floor and ST_WALK for releases
// that have bytes to walk; a result waits in ST_RESULT until the output can take
// it, and the back end takes the next event the cycle after a result loads
// reset: after rst drops, the indicator map is cleared one byte per cycle with
// s_tready low; stack count and last stack pointer reset to 0
module shadow_call_stack_tracker import sct_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int SRAM_SIZE   = DEF_SRAM_SIZE,
  parameter int SRAM_BASE   = DEF_SRAM_BASE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // target_pc, source_pc, sp_addr
  input  logic [OP_W-1:0]       s_tuser,  // op
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata   // depth, top_target, top_source, fault
);

  logic clearing;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  sct_front #(
    .SRAM_SIZE (SRAM_SIZE),
    .SRAM_BASE (SRAM_BASE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .clearing  (clearing),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  sct_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .SRAM_SIZE   (SRAM_SIZE),
    .SRAM_BASE   (SRAM_BASE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .clearing  (clearing),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

/* src/sct_ram.sv */
module sct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/sct_front.sv */
module sct_front import sct_pkg::*; #(
  parameter int SRAM_SIZE = DEF_SRAM_SIZE,
  parameter int SRAM_BASE = DEF_SRAM_BASE
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic [OP_W-1:0]      s_tuser,
  input  logic                 clearing,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output cmd_t                 cmd
);

  localparam int QPW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [ADDR_W:0] WIN_LO = (ADDR_W + 1)'(SRAM_BASE);
  localparam logic [ADDR_W:0] WIN_HI = (ADDR_W + 1)'(SRAM_BASE + SRAM_SIZE);

  cmd_t           q [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QCW-1:0] q_count;

  logic [ADDR_W-1:0] addr;
  logic              in_win;
  cmd_t              cls;
  logic              push;
  logic              pop;

  assign addr   = s_tdata[2*PC_W +: ADDR_W];
  assign in_win = ({1'b0, addr} >= WIN_LO) && ({1'b0, addr} < WIN_HI);

  always_comb begin
    cls.target     = s_tdata[PC_W-1:0];
    cls.source     = s_tdata[PC_W +: PC_W];
    cls.addr       = addr;
    cls.mark_below = ({1'b0, addr} != WIN_LO);
    case (s_tuser)
      OP_CALL:     cls.kind = CMD_PUSH;
      OP_RET_ADDR: cls.kind = in_win ? CMD_MARK : CMD_REPORT;
      OP_RELEASE:  cls.kind = in_win ? CMD_RELEASE : CMD_REPORT;
      default:     cls.kind = CMD_REPORT;
    endcase
  end

  assign s_tready  = !clearing && (q_count != QCW'(QUEUE_DEPTH));
  assign push      = s_tvalid && s_tready;
  assign cmd_valid = (q_count != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        q_count <= q_count + 1'b1;
      end else if (pop && !push) begin
        q_count <= q_count - 1'b1;
      end
    end
  end

endmodule

/* src/sct_back.sv */
module sct_back import sct_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int SRAM_SIZE   = DEF_SRAM_SIZE,
  parameter int SRAM_BASE   = DEF_SRAM_BASE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  cmd_t                  cmd,
  output logic                  clearing,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int SW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int MW = $clog2(SRAM_SIZE);
  localparam logic [ADDR_W:0] WIN_LO  = (ADDR_W + 1)'(SRAM_BASE);
  localparam logic [MW-1:0]   LAST_IX = MW'(SRAM_SIZE - 1);

  typedef enum logic [5:0] {
    ST_CLEAR    = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_MARK_LOW = 6'b000100,
    ST_WALK     = 6'b001000,
    ST_TOP      = 6'b010000,
    ST_RESULT   = 6'b100000
  } state_t;

  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [ADDR_W-1:0]  last_sp, last_sp_next;
  logic [FAULT_W-1:0] fault, fault_next;
  logic [MW-1:0]      idx, idx_next;
  logic [MW-1:0]      walk_end, walk_end_next;

  logic                mk_we, mk_re;
  logic [MW-1:0]       mk_waddr, mk_raddr;
  logic [MARK_W-1:0]   mk_wdata, mk_rdata;
  logic                st_we, st_re;
  logic [SW-1:0]       st_waddr, st_raddr;
  logic [2*PC_W-1:0]   st_wdata, st_rdata;

  logic [CW-1:0]       count_m1;
  logic [ADDR_W:0]     off_full;
  logic [ADDR_W:0]     start_abs;
  logic [ADDR_W:0]     start_full;
  logic                walk_ok;
  logic                out_load;

  logic [DEPTH_W+CW-1:0] depth_ext;
  logic [PC_W-1:0]       top_target, top_source;

  sct_ram #(.WIDTH(MARK_W), .DEPTH(SRAM_SIZE)) u_marks (
    .clk     (clk),
    .wr_en   (mk_we),
    .wr_addr (mk_waddr),
    .wr_data (mk_wdata),
    .rd_en   (mk_re),
    .rd_addr (mk_raddr),
    .rd_data (mk_rdata)
  );

  sct_ram #(.WIDTH(2 * PC_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data (st_wdata),
    .rd_en   (st_re),
    .rd_addr (st_raddr),
    .rd_data (st_rdata)
  );

  assign count_m1 = count - CW'(1);
  assign off_full = {1'b0, cmd.addr} - WIN_LO;

  // walk starts one below the last pointer, clipped to the window floor
  always_comb begin
    if ({1'b0, last_sp} <= WIN_LO) begin
      start_abs = WIN_LO;
    end else begin
      start_abs = {1'b0, last_sp} - (ADDR_W + 1)'(1);
    end
  end
  assign start_full = start_abs - WIN_LO;
  assign walk_ok    = (start_abs <= {1'b0, cmd.addr});
  assign clearing   = (state == ST_CLEAR);

  always_comb begin
    state_next    = state;
    count_next    = count;
    last_sp_next  = last_sp;
    fault_next    = fault;
    idx_next      = idx;
    walk_end_next = walk_end;
    cmd_ready     = 1'b0;
    mk_we         = 1'b0;
    mk_waddr      = idx;
    mk_wdata      = MARK_NONE;
    mk_re         = 1'b0;
    mk_raddr      = idx + 1'b1;
    st_we         = 1'b0;
    st_waddr      = count[SW-1:0];
    st_wdata      = {cmd.source, cmd.target};
    st_re         = 1'b0;
    st_raddr      = count_m1[SW-1:0];
    out_load      = 1'b0;
    case (state)
      ST_CLEAR: begin
        mk_we = 1'b1;
        if (idx == LAST_IX) begin
          idx_next   = '0;
          state_next = ST_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_ready  = 1'b1;
          fault_next = FAULT_NONE;
          state_next = ST_TOP;
          case (cmd.kind)
            CMD_PUSH: begin
              if (count == CW'(STACK_DEPTH)) begin
                fault_next = FAULT_OVERFLOW;
              end else begin
                st_we      = 1'b1;
                count_next = count + 1'b1;
              end
            end
            CMD_MARK: begin
              mk_we        = 1'b1;
              mk_waddr     = off_full[MW-1:0];
              mk_wdata     = MARK_HIGH;
              last_sp_next = cmd.addr;
              idx_next     = off_full[MW-1:0] - 1'b1;
              if (cmd.mark_below) begin
                state_next = ST_MARK_LOW;
              end
            end
            CMD_RELEASE: begin
              last_sp_next = cmd.addr;
              if (walk_ok) begin
                mk_re         = 1'b1;
                mk_raddr      = start_full[MW-1:0];
                idx_next      = start_full[MW-1:0];
                walk_end_next = off_full[MW-1:0];
                state_next    = ST_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MARK_LOW: begin
        mk_we      = 1'b1;
        mk_wdata   = MARK_LOW;
        state_next = ST_TOP;
      end
      ST_WALK: begin
        // mark of idx is on the read port now; clear it and, unless idx is walk_end, fetch the next byte
        mk_we = 1'b1;
        if (mk_rdata == MARK_HIGH) begin
          if (count == '0) begin
            fault_next = FAULT_UNDERFLOW;
          end else begin
            count_next = count - 1'b1;
          end
        end
        if (idx == walk_end) begin
          state_next = ST_TOP;
        end else begin
          idx_next = idx + 1'b1;
          mk_re    = 1'b1;
        end
      end
      ST_TOP: begin
        st_re      = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign depth_ext  = {{DEPTH_W{1'b0}}, count};
  assign top_target = (count == '0) ? '0 : st_rdata[PC_W-1:0];
  assign top_source = (count == '0) ? '0 : st_rdata[PC_W +: PC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      count    <= '0;
      last_sp  <= '0;
      fault    <= FAULT_NONE;
      idx      <= '0;
      walk_end <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      last_sp  <= last_sp_next;
      fault    <= fault_next;
      idx      <= idx_next;
      walk_end <= walk_end_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {(OUT_DATA_W - OUT_BITS)'(0), fault, top_source, top_target,
                  depth_ext[DEPTH_W-1:0]};
    end
  end

endmodule
